/* hdl/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define AARM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define AARM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/aarm_pkg.sv */
// constants and tables for the axis-angle rotation matrix pipeline
package aarm_pkg;

    // field widths
    localparam int IN_W          = 16;
    localparam int OUT_FRAC_BITS = 16;
    localparam int OUT_W         = OUT_FRAC_BITS + 2;
    localparam int Q30_W         = 32;

    // fixed-point constants
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;
    localparam logic [30:0] ONE_Q30  = 31'd1073741824;

    // angle units, 1/64 degree
    localparam int TURN         = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;

    // radian conversion: half turn is 45 * 2^8, pi split into whole steps and a remainder
    localparam logic [18:0] RAD_STEP    = 19'(PI_Q30 / HALF_TURN);
    localparam logic [12:0] RAD_FRAC    = 13'(PI_Q30 % HALF_TURN);
    localparam int          HALF_POW_SH = 8;
    localparam logic [18:0] DIV45_RECIP = 19'd372828;
    localparam int          DIV45_SH    = 24;

    // unit sizes
    localparam int CORDIC_STAGES = 18;
    localparam int SQRT_STAGES   = 32;
    localparam int QUO_BITS      = 31;

    // pipeline depths
    localparam int AXIS_LAT  = 1 + SQRT_STAGES + 1 + QUO_BITS + 1;
    localparam int ANGLE_LAT = 3 + 1 + CORDIC_STAGES + 1;
    localparam int ANGLE_PAD = AXIS_LAT - ANGLE_LAT;
    localparam int MAT_LAT   = 5;
    localparam int LAT       = AXIS_LAT + MAT_LAT;

    // atan(2^-i) in Q2.30
    localparam logic [30:0] ATAN_Q30 [32] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
        31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
        31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
        31'd262144,    31'd131072,    31'd65536,     31'd32768,
        31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128,
        31'd64,        31'd32,        31'd16,        31'd8,
        31'd4,         31'd2,         31'd1,         31'd0
    };

endpackage

/* hdl/aarm_axis.sv */
// axis normalization: squared length, pipelined square root, three pipelined dividers
module aarm_axis
    import aarm_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [IN_W-1:0]  ax,
    input  logic signed [IN_W-1:0]  ay,
    input  logic signed [IN_W-1:0]  az,
    output logic signed [Q30_W-1:0] u_x,
    output logic signed [Q30_W-1:0] u_y,
    output logic signed [Q30_W-1:0] u_z,
    output logic                    zero
);

    localparam int LEN_W    = 2 * IN_W;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = ROOT_W + 4;
    localparam int NUM_SH   = 46;
    localparam int NUM_W    = IN_W + NUM_SH;
    localparam int DV_REM_W = ROOT_W + 1;

    logic signed [IN_W-1:0]   comp [3];
    logic signed [LEN_W-1:0]  sq   [3];
    logic [LEN_W-1:0]         len2_next;

    // square root stages
    logic [LEN_W-1:0]  sq_len_reg  [SQRT_STAGES+1];
    logic [REM_W-1:0]  sq_rem_reg  [SQRT_STAGES+1];
    logic [ROOT_W-1:0] sq_root_reg [SQRT_STAGES+1];
    logic [IN_W-1:0]   sq_mag_reg  [SQRT_STAGES+1][3];
    logic [2:0]        sq_sgn_reg  [SQRT_STAGES+1];
    logic              sq_zero_reg [SQRT_STAGES+1];

    // divider stages
    logic [DV_REM_W-1:0] dv_rem_reg  [QUO_BITS+1][3];
    logic [QUO_BITS-1:0] dv_low_reg  [QUO_BITS+1][3];
    logic [QUO_BITS-1:0] dv_quo_reg  [QUO_BITS+1][3];
    logic [ROOT_W-1:0]   dv_den_reg  [QUO_BITS+1];
    logic [2:0]          dv_sgn_reg  [QUO_BITS+1];
    logic                dv_zero_reg [QUO_BITS+1];

    logic signed [Q30_W-1:0] u_reg [3];
    logic                    zero_reg;

    assign comp[0] = ax;
    assign comp[1] = ay;
    assign comp[2] = az;

    // squared length
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sq[c] = comp[c] * comp[c];
        end
        len2_next = LEN_W'(unsigned'(sq[0])) + LEN_W'(unsigned'(sq[1]))
                  + LEN_W'(unsigned'(sq[2]));
    end

    // entry stage: length, magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_len_reg[0]  <= len2_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int c = 0; c < 3; c++)
            begin
                sq_mag_reg[0][c] <= comp[c][IN_W-1] ? IN_W'(-comp[c]) : IN_W'(comp[c]);
                sq_sgn_reg[0][c] <= comp[c][IN_W-1];
            end
            sq_zero_reg[0] <= (ax == '0) && (ay == '0) && (az == '0);
        end
    end

    // one root bit per stage, radicand is length shifted up by 32
    for (genvar j = 1; j <= SQRT_STAGES; j++)
    begin : g_sqrt
        localparam int PB = 2 * SQRT_STAGES - 2 * j;
        logic [1:0]       pair;
        logic [REM_W-1:0] rsh;
        logic [REM_W-1:0] trial;

        if (PB >= LEN_W)
        begin : g_hi
            assign pair = sq_len_reg[j-1][PB-LEN_W+1:PB-LEN_W];
        end
        else
        begin : g_lo
            assign pair = 2'b00;
        end

        assign rsh   = {sq_rem_reg[j-1][REM_W-3:0], pair};
        assign trial = REM_W'({sq_root_reg[j-1], 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rsh >= trial)
                begin
                    sq_rem_reg[j]  <= rsh - trial;
                    sq_root_reg[j] <= {sq_root_reg[j-1][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[j]  <= rsh;
                    sq_root_reg[j] <= {sq_root_reg[j-1][ROOT_W-2:0], 1'b0};
                end
                sq_len_reg[j]  <= sq_len_reg[j-1];
                sq_mag_reg[j]  <= sq_mag_reg[j-1];
                sq_sgn_reg[j]  <= sq_sgn_reg[j-1];
                sq_zero_reg[j] <= sq_zero_reg[j-1];
            end
        end
    end

    // numerator setup: magnitude scaled by 2^46 plus half the root
    always_ff @(posedge clk)
    begin
        logic [NUM_W-1:0] num;
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                num = {sq_mag_reg[SQRT_STAGES][c], {NUM_SH{1'b0}}}
                    + NUM_W'(sq_root_reg[SQRT_STAGES] >> 1);
                dv_rem_reg[0][c] <= DV_REM_W'(num[NUM_W-1:QUO_BITS]);
                dv_low_reg[0][c] <= num[QUO_BITS-1:0];
                dv_quo_reg[0][c] <= '0;
            end
            dv_den_reg[0]  <= sq_root_reg[SQRT_STAGES];
            dv_sgn_reg[0]  <= sq_sgn_reg[SQRT_STAGES];
            dv_zero_reg[0] <= sq_zero_reg[SQRT_STAGES];
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 1; k <= QUO_BITS; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            logic [DV_REM_W-1:0] rsh;
            if (en)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rsh = {dv_rem_reg[k-1][c][DV_REM_W-2:0],
                           dv_low_reg[k-1][c][QUO_BITS-k]};
                    if (rsh >= {1'b0, dv_den_reg[k-1]})
                    begin
                        dv_rem_reg[k][c] <= rsh - {1'b0, dv_den_reg[k-1]};
                        dv_quo_reg[k][c] <= {dv_quo_reg[k-1][c][QUO_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[k][c] <= rsh;
                        dv_quo_reg[k][c] <= {dv_quo_reg[k-1][c][QUO_BITS-2:0], 1'b0};
                    end
                end
                dv_low_reg[k]  <= dv_low_reg[k-1];
                dv_den_reg[k]  <= dv_den_reg[k-1];
                dv_sgn_reg[k]  <= dv_sgn_reg[k-1];
                dv_zero_reg[k] <= dv_zero_reg[k-1];
            end
        end
    end

    // clamp to one and restore sign
    always_ff @(posedge clk)
    begin
        logic [QUO_BITS-1:0] q;
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                q = dv_quo_reg[QUO_BITS][c];
                if (q > ONE_Q30)
                begin
                    q = ONE_Q30;
                end
                u_reg[c] <= dv_sgn_reg[QUO_BITS][c] ? -Q30_W'({1'b0, q}) : Q30_W'({1'b0, q});
            end
            zero_reg <= dv_zero_reg[QUO_BITS];
        end
    end

    assign u_x  = u_reg[0];
    assign u_y  = u_reg[1];
    assign u_z  = u_reg[2];
    assign zero = zero_reg;

endmodule

/* hdl/aarm_angle.sv */
// angle path: turn reduction, radian conversion by reciprocal multiplication, CORDIC sine and cosine
module aarm_angle
    import aarm_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [IN_W-1:0]  angle,
    output logic signed [Q30_W-1:0] cos_q,
    output logic signed [Q30_W-1:0] sin_q
);

    localparam int MAG_W = 13;
    localparam int HI_W  = 32;
    localparam int LO_W  = 26;
    localparam int LQ_W  = LO_W - HALF_POW_SH;
    localparam int LP_W  = LQ_W + 19;
    localparam int CW    = 34;
    localparam int A17   = IN_W + 1;

    localparam logic signed [CW-1:0] ONE_C = CW'(ONE_Q30);

    logic signed [A17-1:0] r1;
    logic signed [A17-1:0] r2;
    logic                  fold;
    logic [MAG_W-1:0]      mag;
    logic [LP_W-1:0]       lq_prod;

    logic [MAG_W-1:0] an_mag_reg;
    logic             an_sgn_reg;
    logic             an_neg_reg;
    logic [HI_W-1:0]  rd_hi_reg;
    logic [LO_W-1:0]  rd_lo_reg;
    logic             rd_sgn_reg;
    logic             rd_neg_reg;
    logic [HI_W-1:0]  th_mag_reg;
    logic             th_sgn_reg;
    logic             th_neg_reg;

    logic signed [CW-1:0] cx_reg  [CORDIC_STAGES+1];
    logic signed [CW-1:0] cy_reg  [CORDIC_STAGES+1];
    logic signed [CW-1:0] cz_reg  [CORDIC_STAGES+1];
    logic                 cneg_reg[CORDIC_STAGES+1];

    logic signed [Q30_W-1:0] cos_reg [ANGLE_PAD+1];
    logic signed [Q30_W-1:0] sin_reg [ANGLE_PAD+1];

    // reduce into one turn, fold into plus or minus a quarter turn
    always_comb
    begin
        r1 = A17'(angle);
        if (r1 >= A17'(HALF_TURN))
        begin
            r1 = r1 - A17'(TURN);
        end
        else if (r1 < -A17'(HALF_TURN))
        begin
            r1 = r1 + A17'(TURN);
        end
        r2   = r1;
        fold = 1'b0;
        if (r1 > A17'(QUARTER_TURN))
        begin
            r2   = r1 - A17'(HALF_TURN);
            fold = 1'b1;
        end
        else if (r1 < -A17'(QUARTER_TURN))
        begin
            r2   = r1 + A17'(HALF_TURN);
            fold = 1'b1;
        end
        mag = r2[A17-1] ? MAG_W'(-r2) : MAG_W'(r2);
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_mag_reg <= mag;
            an_sgn_reg <= r2[A17-1];
            an_neg_reg <= fold;
        end
    end

    // whole pi steps and the remainder term of the half-turn division
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_hi_reg  <= HI_W'(an_mag_reg) * HI_W'(RAD_STEP);
            rd_lo_reg  <= LO_W'(an_mag_reg) * LO_W'(RAD_FRAC) + LO_W'(QUARTER_TURN);
            rd_sgn_reg <= an_sgn_reg;
            rd_neg_reg <= an_neg_reg;
        end
    end

    // remainder term over 2^8 times 45 by reciprocal multiplication
    assign lq_prod = LP_W'(rd_lo_reg[LO_W-1:HALF_POW_SH]) * LP_W'(DIV45_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_mag_reg <= rd_hi_reg + HI_W'(lq_prod[LP_W-1:DIV45_SH]);
            th_sgn_reg <= rd_sgn_reg;
            th_neg_reg <= rd_neg_reg;
        end
    end

    // CORDIC start vector
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]   <= CW'(GAIN_Q30);
            cy_reg[0]   <= '0;
            cz_reg[0]   <= th_sgn_reg ? -CW'(th_mag_reg) : CW'(th_mag_reg);
            cneg_reg[0] <= th_neg_reg;
        end
    end

    // rotation-mode CORDIC micro-rotations
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        assign at = CW'(ATAN_Q30[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cz_reg[i][CW-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - at;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + at;
                end
                cneg_reg[i+1] <= cneg_reg[i];
            end
        end
    end

    // unfold sign and clamp to one
    always_ff @(posedge clk)
    begin
        logic signed [CW-1:0] xv;
        logic signed [CW-1:0] yv;
        if (en)
        begin
            xv = cneg_reg[CORDIC_STAGES] ? -cx_reg[CORDIC_STAGES] : cx_reg[CORDIC_STAGES];
            yv = cneg_reg[CORDIC_STAGES] ? -cy_reg[CORDIC_STAGES] : cy_reg[CORDIC_STAGES];
            if (xv > ONE_C)
            begin
                xv = ONE_C;
            end
            else if (xv < -ONE_C)
            begin
                xv = -ONE_C;
            end
            if (yv > ONE_C)
            begin
                yv = ONE_C;
            end
            else if (yv < -ONE_C)
            begin
                yv = -ONE_C;
            end
            cos_reg[0] <= Q30_W'(xv);
            sin_reg[0] <= Q30_W'(yv);
        end
    end

    // delay to line up with the axis path
    for (genvar d = 1; d <= ANGLE_PAD; d++)
    begin : g_pad
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cos_reg[d] <= cos_reg[d-1];
                sin_reg[d] <= sin_reg[d-1];
            end
        end
    end

    assign cos_q = cos_reg[ANGLE_PAD];
    assign sin_q = sin_reg[ANGLE_PAD];

endmodule

/* hdl/axis_angle_rotation_matrix.sv */
// Depth: 66-stage axis/angle front and 5 matrix stages from accepted item to result.
// Throughput: one item per cycle unless stalled; square root and divider stages set the depth.
// All stages advance together; the whole pipeline holds while a result is stalled.
// Reset clears only the valid bits; data registers are not reset.
// top level: rotation matrix from axis and angle
module axis_angle_rotation_matrix
    import aarm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [IN_W-1:0] axis_x,
    input  logic signed [IN_W-1:0] axis_y,
    input  logic signed [IN_W-1:0] axis_z,
    input  logic signed [IN_W-1:0] angle_deg,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [OUT_W-1:0] r00,
    output logic signed [OUT_W-1:0] r01,
    output logic signed [OUT_W-1:0] r02,
    output logic signed [OUT_W-1:0] r10,
    output logic signed [OUT_W-1:0] r11,
    output logic signed [OUT_W-1:0] r12,
    output logic signed [OUT_W-1:0] r20,
    output logic signed [OUT_W-1:0] r21,
    output logic signed [OUT_W-1:0] r22,
    output logic                   axis_zero
);

    localparam int PW  = 2 * Q30_W;
    localparam int TW  = Q30_W + 1;
    localparam int SH  = 60 - OUT_FRAC_BITS;

    logic                    en;
    logic [LAT-1:0]          vld_reg;
    logic signed [Q30_W-1:0] u   [3];
    logic signed [Q30_W-1:0] cq;
    logic signed [Q30_W-1:0] sq;
    logic                    zero_u;

    logic signed [PW-1:0]    m1_pp_reg [6];
    logic signed [PW-1:0]    m1_us_reg [3];
    logic signed [TW-1:0]    m1_t_reg;
    logic signed [Q30_W-1:0] m1_c_reg;
    logic signed [Q30_W-1:0] m2_p_reg  [6];
    logic signed [PW-1:0]    m2_us_reg [3];
    logic signed [TW-1:0]    m2_t_reg;
    logic signed [Q30_W-1:0] m2_c_reg;
    logic signed [PW-1:0]    m3_pt_reg [6];
    logic signed [PW-1:0]    m3_us_reg [3];
    logic signed [Q30_W-1:0] m3_c_reg;
    logic signed [PW-1:0]    m4_ent_reg[9];
    logic signed [OUT_W-1:0] r_reg     [9];
    logic [MAT_LAT-1:0]      zero_reg;

    // global advance: hold only when a result is waiting and stalled
    assign en       = !vld_reg[LAT-1] || !out_stall;
    assign in_stall = !en;

    aarm_axis u_axis (
        .clk  (clk),
        .en   (en),
        .ax   (axis_x),
        .ay   (axis_y),
        .az   (axis_z),
        .u_x  (u[0]),
        .u_y  (u[1]),
        .u_z  (u[2]),
        .zero (zero_u)
    );

    aarm_angle u_angle (
        .clk   (clk),
        .en    (en),
        .angle (angle_deg),
        .cos_q (cq),
        .sin_q (sq)
    );

    // valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // m1: axis products and sine terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_pp_reg[0] <= u[0] * u[0];
            m1_pp_reg[1] <= u[0] * u[1];
            m1_pp_reg[2] <= u[0] * u[2];
            m1_pp_reg[3] <= u[1] * u[1];
            m1_pp_reg[4] <= u[1] * u[2];
            m1_pp_reg[5] <= u[2] * u[2];
            for (int k = 0; k < 3; k++)
            begin
                m1_us_reg[k] <= u[k] * sq;
            end
            m1_t_reg <= TW'(ONE_Q30) - TW'(cq);
            m1_c_reg <= cq;
        end
    end

    // m2: round outer products to Q2.30
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
            begin
                m2_p_reg[k] <= Q30_W'((m1_pp_reg[k] + PW'(ONE_Q30 >> 1)) >>> 30);
            end
            m2_us_reg <= m1_us_reg;
            m2_t_reg  <= m1_t_reg;
            m2_c_reg  <= m1_c_reg;
        end
    end

    // m3: scale by one minus cosine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
            begin
                m3_pt_reg[k] <= PW'(m2_p_reg[k]) * PW'(m2_t_reg);
            end
            m3_us_reg <= m2_us_reg;
            m3_c_reg  <= m2_c_reg;
        end
    end

    // m4: matrix entries in Q.60
    always_ff @(posedge clk)
    begin
        logic signed [PW-1:0] cd;
        if (en)
        begin
            cd = PW'(m3_c_reg) <<< 30;
            m4_ent_reg[0] <= m3_pt_reg[0] + cd;
            m4_ent_reg[1] <= m3_pt_reg[1] - m3_us_reg[2];
            m4_ent_reg[2] <= m3_pt_reg[2] + m3_us_reg[1];
            m4_ent_reg[3] <= m3_pt_reg[1] + m3_us_reg[2];
            m4_ent_reg[4] <= m3_pt_reg[3] + cd;
            m4_ent_reg[5] <= m3_pt_reg[4] - m3_us_reg[0];
            m4_ent_reg[6] <= m3_pt_reg[2] - m3_us_reg[1];
            m4_ent_reg[7] <= m3_pt_reg[4] + m3_us_reg[0];
            m4_ent_reg[8] <= m3_pt_reg[5] + cd;
        end
    end

    // output: round half up, saturate to plus or minus one, zero axis forces zero
    always_ff @(posedge clk)
    begin
        logic signed [PW-1:0] rv;
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                rv = (m4_ent_reg[k] + (PW'(1) <<< (SH - 1))) >>> SH;
                if (rv > (PW'(1) <<< OUT_FRAC_BITS))
                begin
                    rv = PW'(1) <<< OUT_FRAC_BITS;
                end
                else if (rv < -(PW'(1) <<< OUT_FRAC_BITS))
                begin
                    rv = -(PW'(1) <<< OUT_FRAC_BITS);
                end
                r_reg[k] <= zero_reg[MAT_LAT-2] ? '0 : OUT_W'(rv);
            end
        end
    end

    // zero-axis flag alongside the matrix stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= {zero_reg[MAT_LAT-2:0], zero_u};
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign axis_zero = zero_reg[MAT_LAT-1];
    assign r00 = r_reg[0];
    assign r01 = r_reg[1];
    assign r02 = r_reg[2];
    assign r10 = r_reg[3];
    assign r11 = r_reg[4];
    assign r12 = r_reg[5];
    assign r20 = r_reg[6];
    assign r21 = r_reg[7];
    assign r22 = r_reg[8];

endmodule

/* hdl/aarm_checker.sv */
// port-level checks for the rotation matrix block, bound to the top level
`include "assert_macros.svh"

module aarm_checker
    import aarm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic signed [IN_W-1:0]  axis_x,
    input logic signed [IN_W-1:0]  axis_y,
    input logic signed [IN_W-1:0]  axis_z,
    input logic signed [IN_W-1:0]  angle_deg,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [OUT_W-1:0] r00,
    input logic signed [OUT_W-1:0] r01,
    input logic signed [OUT_W-1:0] r02,
    input logic signed [OUT_W-1:0] r10,
    input logic signed [OUT_W-1:0] r11,
    input logic signed [OUT_W-1:0] r12,
    input logic signed [OUT_W-1:0] r20,
    input logic signed [OUT_W-1:0] r21,
    input logic signed [OUT_W-1:0] r22,
    input logic                    axis_zero
);

    logic all_zero;
    logic in_take;

    // matrix is all zero
    assign all_zero = (r00 == '0) && (r01 == '0) && (r02 == '0) && (r10 == '0)
                   && (r11 == '0) && (r12 == '0) && (r20 == '0) && (r21 == '0)
                   && (r22 == '0);

    // an item with a zero axis enters
    assign in_take = in_valid && !in_stall && (axis_x == '0) && (axis_y == '0)
                  && (axis_z == '0) && (angle_deg == angle_deg);

    // input is held back exactly when a result waits under stall
    `AARM_ASSERT(a_flow, in_stall == (out_valid && out_stall), "input stall mismatch")
    // zero-axis result carries an all-zero matrix
    `AARM_ASSERT(a_zero, (out_valid && axis_zero) |-> all_zero, "zero axis with nonzero matrix")
    // a stalled result stays
    `AARM_ASSERT_NEXT(a_keep, out_valid && out_stall, out_valid, "stalled item dropped")
    // a stalled result keeps r00 and the zero-axis flag unchanged
    `AARM_ASSERT_NEXT(a_hold, out_valid && out_stall, $stable(r00) && $stable(axis_zero), "stalled item changed")
    // a zero-axis item is never taken while a result waits under stall
    `AARM_ASSERT(a_take, in_take |-> !(out_valid && out_stall), "item taken while blocked")

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (.*);
